@@ sv/bfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_pkg
// Widths, types and the Blatt-Weisskopf coefficient table for the barrier
// factor ratio pipeline.
// ----------------------------------------------------------------------------
package bfr_pkg;

  localparam int MOM_W     = 24;
  localparam int RAD_W     = 16;
  localparam int ORD_W     = 3;
  localparam int Z_W       = 25;
  localparam int ZFRAC     = 13;
  localparam int S_W       = MOM_W + RAD_W;
  localparam int SQ_W      = 2 * S_W;
  localparam int SQ_SHIFT  = SQ_W - Z_W;
  localparam int ACC_W     = 128;
  localparam int LIMB_W    = 32;
  localparam int LIMBS     = ACC_W / LIMB_W;
  localparam int PP_W      = LIMB_W + Z_W;
  localparam int QUO_W     = 96;
  localparam int FRAC_W    = 48;
  localparam int NUM_LO_W  = QUO_W - FRAC_W;
  localparam int ROOT_W    = QUO_W / 2;
  localparam int SREM_W    = ROOT_W + 2;
  localparam int RATIO_W   = 48;
  localparam int MAX_ORDER = 5;
  localparam int COEF_W    = 20;

  localparam logic [RAD_W-1:0]   RADIUS_RESET = 16'd24576;
  localparam logic [RATIO_W-1:0] RATIO_ONE    = 48'h00_0001_000000;

  typedef logic [ORD_W-1:0] ord_t;
  typedef logic [Z_W-1:0]   z_t;
  typedef logic [ACC_W-1:0] acc_t;

  // Unscaled polynomial coefficients, row by order, column by power of z.
  localparam logic [COEF_W-1:0] BW_COEF [MAX_ORDER+1][MAX_ORDER+1] = '{
    '{20'd1,      20'd0,     20'd0,    20'd0,   20'd0,  20'd0},
    '{20'd1,      20'd1,     20'd0,    20'd0,   20'd0,  20'd0},
    '{20'd9,      20'd3,     20'd1,    20'd0,   20'd0,  20'd0},
    '{20'd225,    20'd45,    20'd6,    20'd1,   20'd0,  20'd0},
    '{20'd11025,  20'd1575,  20'd135,  20'd10,  20'd1,  20'd0},
    '{20'd893025, 20'd99225, 20'd6300, 20'd315, 20'd15, 20'd1}
  };

  // Coefficient of z^k in B_l, scaled to the common fixed-point weight.
  function automatic acc_t bw_term(ord_t l, ord_t k);
    acc_t term;
    term = '0;
    if ((l <= ord_t'(MAX_ORDER)) && (k < l)) begin
      term = acc_t'(BW_COEF[l][k]) << (ZFRAC * (int'(l) - int'(k)));
    end
    return term;
  endfunction

endpackage

@@ sv/bfr_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_req_if
// Input channel: one item carries two momenta and an orbital order.
// ----------------------------------------------------------------------------
interface bfr_req_if;
  import bfr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MOM_W-1:0]     nominal_momentum;
  logic [MOM_W-1:0]     actual_momentum;
  logic [ORD_W-1:0]     angular_order;

  modport source (output valid, nominal_momentum, actual_momentum, angular_order,
                  input ready);
  modport sink   (input valid, nominal_momentum, actual_momentum, angular_order,
                  output ready);
endinterface

@@ sv/bfr_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_rsp_if
// Output channel: one item carries the ratio and its saturation flag.
// ----------------------------------------------------------------------------
interface bfr_rsp_if;
  import bfr_pkg::*;

  logic               valid;
  logic               ready;
  logic [RATIO_W-1:0] factor_ratio;
  logic               saturated;

  modport source (output valid, factor_ratio, saturated, input ready);
  modport sink   (input valid, factor_ratio, saturated, output ready);
endinterface

@@ sv/barrier_factor_ratio.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barrier_factor_ratio
// Pipelined Blatt-Weisskopf barrier factor ratio sqrt(B_L(z0) / B_L(z)).
// ----------------------------------------------------------------------------
// Items enter on req (valid/ready) with two Q3.21 momenta and an order L,
// and leave on rsp with a Q24.24 ratio and a saturation flag, in order.
// The radius is a Q3.13 register written through cfg_wr_en / cfg_wr_data; it
// resets to 3.0. The user must write it only while the pipeline is empty;
// the block itself does not enforce this. Items pass through the z stages,
// the five Horner steps, the divider stages, the square root stages and the
// output register, all fully pipelined, so one item is taken every cycle
// unless rsp is stalled. Order 0 returns 1.0 and orders 6 and 7 return 0.
// When rsp is stalled the whole pipeline holds, req.ready drops, and no item
// is lost or repeated. Reset empties the pipeline and restores the radius.
// ----------------------------------------------------------------------------
module barrier_factor_ratio (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [bfr_pkg::RAD_W-1:0] cfg_wr_data,
  bfr_req_if.sink                   req,
  bfr_rsp_if.source                 rsp
);
  import bfr_pkg::*;

  logic             en;
  logic [RAD_W-1:0] radius;
  logic             z_v, p_v, d_v, r_v;
  ord_t             z_ord, p_ord, d_ord, r_ord;
  z_t               z0, z1;
  acc_t             num, den;
  logic [QUO_W-1:0] quo;
  logic [ROOT_W-1:0] root;
  logic [RATIO_W-1:0] ratio_next;

  // The pipeline moves whenever the output register can take an item.
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // Radius register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius <= cfg_wr_data;
    end
  end

  bfr_zgen u_zgen (
    .clk, .rst, .en,
    .vin     (req.valid),
    .ord_in  (req.angular_order),
    .mom0    (req.nominal_momentum),
    .mom1    (req.actual_momentum),
    .radius,
    .vout    (z_v),
    .ord_out (z_ord),
    .z0, .z1
  );

  bfr_poly u_poly (
    .clk, .rst, .en,
    .vin (z_v), .ord_in (z_ord), .z0, .z1,
    .vout (p_v), .ord_out (p_ord), .num, .den
  );

  bfr_div u_div (
    .clk, .rst, .en,
    .vin (p_v), .ord_in (p_ord), .num, .den,
    .vout (d_v), .ord_out (d_ord), .quo
  );

  bfr_sqrt u_sqrt (
    .clk, .rst, .en,
    .vin (d_v), .ord_in (d_ord), .radicand (quo),
    .vout (r_v), .ord_out (r_ord), .root
  );

  // Special orders override the computed root; the root fits in 48 bits.
  always_comb begin
    if (r_ord == ord_t'(0)) begin
      ratio_next = RATIO_ONE;
    end else if (r_ord > ord_t'(MAX_ORDER)) begin
      ratio_next = '0;
    end else begin
      ratio_next = RATIO_W'(root);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.factor_ratio <= ratio_next;
      rsp.saturated    <= 1'b0;
    end
  end

  // The output is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("output valid after reset");

  // A stalled output must hold off new items.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !req.ready)
    else $error("input accepted while output stalled");

  // A stall freezes the internal valid chain.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> $stable(d_v) && $stable(r_v))
    else $error("pipeline moved during stall");

endmodule

@@ sv/bfr_zgen.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_zgen
// Three-stage generation of z = (p*r)^2 in Q12.13 for both momenta.
// ----------------------------------------------------------------------------
module bfr_zgen (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vin,
  input  bfr_pkg::ord_t             ord_in,
  input  logic [bfr_pkg::MOM_W-1:0] mom0,
  input  logic [bfr_pkg::MOM_W-1:0] mom1,
  input  logic [bfr_pkg::RAD_W-1:0] radius,
  output logic                      vout,
  output bfr_pkg::ord_t             ord_out,
  output bfr_pkg::z_t               z0,
  output bfr_pkg::z_t               z1
);
  import bfr_pkg::*;

  localparam int HI_W = S_W - LIMB_W;

  logic [2:0]            v;
  ord_t                  ord1, ord2;
  logic [S_W-1:0]        s [2];
  logic [2*LIMB_W-1:0]   ll [2];
  logic [S_W-1:0]        lh [2];
  logic [2*HI_W-1:0]     hh [2];
  logic [SQ_W-1:0]       sq [2];

  // Valid bits advance with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], vin};
    end
  end

  // The square is split into partial products of at most 32 bits a side.
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      sq[j] = SQ_W'(ll[j]) + (SQ_W'(lh[j]) << (LIMB_W + 1))
            + (SQ_W'(hh[j]) << (2 * LIMB_W));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s[0] <= S_W'(mom0) * S_W'(radius);
      s[1] <= S_W'(mom1) * S_W'(radius);
      ord1 <= ord_in;
      for (int j = 0; j < 2; j++) begin
        ll[j] <= (2*LIMB_W)'(s[j][LIMB_W-1:0]) * (2*LIMB_W)'(s[j][LIMB_W-1:0]);
        lh[j] <= S_W'(s[j][LIMB_W-1:0]) * S_W'(s[j][S_W-1:LIMB_W]);
        hh[j] <= (2*HI_W)'(s[j][S_W-1:LIMB_W]) * (2*HI_W)'(s[j][S_W-1:LIMB_W]);
      end
      ord2 <= ord1;
      z0   <= sq[0][SQ_W-1:SQ_SHIFT];
      z1   <= sq[1][SQ_W-1:SQ_SHIFT];
      ord_out <= ord2;
    end
  end

  assign vout = v[2];

endmodule

@@ sv/bfr_poly.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_poly
// Horner evaluation of B_L at both z values, two register stages per step.
// ----------------------------------------------------------------------------
module bfr_poly (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  bfr_pkg::ord_t ord_in,
  input  bfr_pkg::z_t   z0,
  input  bfr_pkg::z_t   z1,
  output logic          vout,
  output bfr_pkg::ord_t ord_out,
  output bfr_pkg::acc_t num,
  output bfr_pkg::acc_t den
);
  import bfr_pkg::*;

  logic [MAX_ORDER:0] sv;
  ord_t               s_ord [MAX_ORDER+1];
  z_t                 s_z   [MAX_ORDER+1][2];
  acc_t               s_acc [MAX_ORDER+1][2];

  assign sv[0]       = vin;
  assign s_ord[0]    = ord_in;
  assign s_z[0][0]   = z0;
  assign s_z[0][1]   = z1;
  assign s_acc[0][0] = acc_t'(1);
  assign s_acc[0][1] = acc_t'(1);

  for (genvar s = 0; s < MAX_ORDER; s++) begin : g_step
    localparam ord_t K = ord_t'(MAX_ORDER - 1 - s);

    logic         a_v;
    ord_t         a_ord;
    z_t           a_z   [2];
    logic [PP_W-1:0] a_pp [2][LIMBS];
    acc_t         a_term;
    logic         a_act;
    acc_t         b_sum [2];

    // Steps ahead of the highest power for this order leave the value at one.
    always_ff @(posedge clk) begin
      if (rst) begin
        a_v       <= 1'b0;
        sv[s+1]   <= 1'b0;
      end else if (en) begin
        a_v       <= sv[s];
        sv[s+1]   <= a_v;
      end
    end

    // Sum the limb products and add the scaled coefficient.
    always_comb begin
      for (int j = 0; j < 2; j++) begin
        b_sum[j] = a_term;
        for (int q = 0; q < LIMBS; q++) begin
          b_sum[j] = b_sum[j] + (acc_t'(a_pp[j][q]) << (q * LIMB_W));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_ord  <= s_ord[s];
        a_term <= bw_term(s_ord[s], K);
        a_act  <= (K < s_ord[s]) && (s_ord[s] <= ord_t'(MAX_ORDER));
        for (int j = 0; j < 2; j++) begin
          a_z[j] <= s_z[s][j];
          for (int q = 0; q < LIMBS; q++) begin
            a_pp[j][q] <= PP_W'(s_acc[s][j][q*LIMB_W +: LIMB_W]) * PP_W'(s_z[s][j]);
          end
        end
        s_ord[s+1] <= a_ord;
        for (int j = 0; j < 2; j++) begin
          s_z[s+1][j]   <= a_z[j];
          s_acc[s+1][j] <= a_act ? b_sum[j] : acc_t'(1);
        end
      end
    end
  end

  assign vout    = sv[MAX_ORDER];
  assign ord_out = s_ord[MAX_ORDER];
  assign num     = s_acc[MAX_ORDER][0];
  assign den     = s_acc[MAX_ORDER][1];

endmodule

@@ sv/bfr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_div
// Restoring divider, one quotient bit per stage, forming num * 2^48 / den.
// The quotient stays below 2^96, so only its low 96 bits are developed.
// ----------------------------------------------------------------------------
module bfr_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vin,
  input  bfr_pkg::ord_t             ord_in,
  input  bfr_pkg::acc_t             num,
  input  bfr_pkg::acc_t             den,
  output logic                      vout,
  output bfr_pkg::ord_t             ord_out,
  output logic [bfr_pkg::QUO_W-1:0] quo
);
  import bfr_pkg::*;

  logic [QUO_W:0]   dv;
  ord_t             d_ord [QUO_W+1];
  acc_t             d_rem [QUO_W+1];
  acc_t             d_den [QUO_W+1];
  logic [QUO_W-1:0] d_w   [QUO_W+1];

  // The high part of the numerator is below den and starts as remainder;
  // the word holds dividend bits still to come, then the quotient bits.
  assign dv[0]    = vin;
  assign d_ord[0] = ord_in;
  assign d_rem[0] = acc_t'(num[ACC_W-1:NUM_LO_W]);
  assign d_den[0] = den;
  assign d_w[0]   = {num[NUM_LO_W-1:0], FRAC_W'(0)};

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [ACC_W:0] t;
    logic [ACC_W:0] diff;
    logic           ge;

    assign t    = {d_rem[s], d_w[s][QUO_W-1]};
    assign diff = t - {1'b0, d_den[s]};
    assign ge   = t >= {1'b0, d_den[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s+1] <= 1'b0;
      end else if (en) begin
        dv[s+1] <= dv[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_ord[s+1] <= d_ord[s];
        d_den[s+1] <= d_den[s];
        d_rem[s+1] <= ge ? diff[ACC_W-1:0] : t[ACC_W-1:0];
        d_w[s+1]   <= {d_w[s][QUO_W-2:0], ge};
      end
    end
  end

  assign vout    = dv[QUO_W];
  assign ord_out = d_ord[QUO_W];
  assign quo     = d_w[QUO_W];

endmodule

@@ sv/bfr_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfr_sqrt
// Digit-by-digit integer square root, one root bit per stage, rounded down.
// ----------------------------------------------------------------------------
module bfr_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       vin,
  input  bfr_pkg::ord_t              ord_in,
  input  logic [bfr_pkg::QUO_W-1:0]  radicand,
  output logic                       vout,
  output bfr_pkg::ord_t              ord_out,
  output logic [bfr_pkg::ROOT_W-1:0] root
);
  import bfr_pkg::*;

  logic [ROOT_W:0]    qv;
  ord_t               q_ord  [ROOT_W+1];
  logic [SREM_W-1:0]  q_rem  [ROOT_W+1];
  logic [ROOT_W-1:0]  q_root [ROOT_W+1];
  logic [QUO_W-1:0]   q_w    [ROOT_W+1];

  assign qv[0]     = vin;
  assign q_ord[0]  = ord_in;
  assign q_rem[0]  = '0;
  assign q_root[0] = '0;
  assign q_w[0]    = radicand;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [SREM_W-1:0] t;
    logic [SREM_W-1:0] trial;
    logic              ge;

    // Bring down the next two radicand bits and try root bit one.
    assign t     = {q_rem[s][ROOT_W-1:0], q_w[s][QUO_W-1 -: 2]};
    assign trial = {q_root[s], 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        qv[s+1] <= 1'b0;
      end else if (en) begin
        qv[s+1] <= qv[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_ord[s+1]  <= q_ord[s];
        q_rem[s+1]  <= ge ? (t - trial) : t;
        q_root[s+1] <= {q_root[s][ROOT_W-2:0], ge};
        q_w[s+1]    <= {q_w[s][QUO_W-3:0], 2'b00};
      end
    end
  end

  assign vout    = qv[ROOT_W];
  assign ord_out = q_ord[ROOT_W];
  assign root    = q_root[ROOT_W];

endmodule

@@ tb/barrier_factor_ratio_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barrier_factor_ratio_test
// Drives random momentum pairs and orders through the barrier factor ratio
// pipeline and checks every ratio against an exact integer prediction. The
// radius is changed between phases, including its extremes.
// ----------------------------------------------------------------------------
module barrier_factor_ratio_test;
  import bfr_pkg::*;

  localparam int LATENCY = 158;
  localparam int CYCLE_LIMIT = 400000;

  // Expected ratio and flag for one item.
  typedef struct {
    logic [RATIO_W-1:0] ratio;
    logic               sat;
  } ratio_t;

  // Keeps the expected ratios in order and checks the outputs against them.
  class ratio_board;
    ratio_t pending[$];
    int     mismatches;
    int     checked;

    function void note_item(ratio_t r);
      pending.push_back(r);
    endfunction

    function void check_ratio(logic [RATIO_W-1:0] ratio, logic sat);
      ratio_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ratio 0x%0h arrived with none pending", ratio);
        return;
      end
      want = pending.pop_front();
      if (want.ratio !== ratio || want.sat !== sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ratio mismatch: expected 0x%0h sat %0b, got 0x%0h sat %0b",
                   want.ratio, want.sat, ratio, sat);
      end
    endfunction
  endclass

  logic             clk = 0;
  logic             rst = 1;
  logic             cfg_wr_en = 0;
  logic [RAD_W-1:0] cfg_wr_data = '0;
  logic [RAD_W-1:0] radius = RADIUS_RESET;
  int               cycles = 0;
  int               items_sent = 0;
  bit               long_hold = 0;
  bit               stall_on = 1;
  ratio_board       board;

  bfr_req_if req();
  bfr_rsp_if rsp();

  barrier_factor_ratio i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req.sink),
    .rsp        (rsp.source)
  );

  always #5 clk = ~clk;

  // B_L(z) scaled by 2^(13L), by Horner's rule.
  function automatic logic [255:0] barrier_poly(logic [Z_W-1:0] z, int l);
    logic [255:0] acc;
    logic [255:0] c;
    acc = 1;
    for (int k = l - 1; k >= 0; k--) begin
      c = BW_COEF[l][k];
      acc = acc * z + (c << ((l - k) * ZFRAC));
    end
    return acc;
  endfunction

  function automatic logic [Z_W-1:0] z_of(logic [MOM_W-1:0] mom, logic [RAD_W-1:0] rad);
    logic [79:0] s;
    s = mom * rad;
    s = s * s;
    return Z_W'(s >> 55);
  endfunction

  function automatic ratio_t predict_ratio(logic [MOM_W-1:0] p0, logic [MOM_W-1:0] p,
                                           logic [ORD_W-1:0] l);
    ratio_t       r;
    logic [255:0] quo;
    logic [127:0] root;
    logic [127:0] t;
    r.sat = 0;
    r.ratio = '0;
    if (l == 0) begin
      r.ratio = RATIO_ONE;
    end else if (l <= MAX_ORDER) begin
      quo = (barrier_poly(z_of(p0, radius), l) << 48) / barrier_poly(z_of(p, radius), l);
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        t = root | (128'd1 << b);
        if ({128'd0, t * t} <= quo) root = t;
      end
      if (root > 128'hFFFF_FFFF_FFFF) begin
        root = 128'hFFFF_FFFF_FFFF;
        r.sat = 1;
      end
      r.ratio = root[RATIO_W-1:0];
    end
    return r;
  endfunction

  // Offer one item and wait until it is taken.
  task automatic send_item(logic [MOM_W-1:0] p0, logic [MOM_W-1:0] p, logic [ORD_W-1:0] l);
    req.valid <= 1;
    req.nominal_momentum <= p0;
    req.actual_momentum <= p;
    req.angular_order <= l;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    board.note_item(predict_ratio(p0, p, l));
    items_sent++;
  endtask

  task automatic send_idle(int n);
    req.valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [MOM_W-1:0] rand_mom();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return MOM_W'($urandom_range(0, 4096));
      3: return MOM_W'($urandom_range(1 << 20, 1 << 22));
      default: return MOM_W'($urandom());
    endcase
  endfunction

  task automatic random_items(int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = (left < 40) ? left : $urandom_range(1, 40);
      for (int i = 0; i < burst; i++)
        send_item(rand_mom(), rand_mom(), ORD_W'($urandom()));
      left -= burst;
      if ($urandom_range(0, 3) != 0) send_idle($urandom_range(1, 8));
    end
    send_idle(1);
  endtask

  // Wait for the pipeline to empty, then load a new radius.
  task automatic set_radius(logic [RAD_W-1:0] value);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 0;
    radius = value;
  endtask

  // Receiver stall pattern, with a long hold when requested.
  always @(posedge clk) begin
    if (long_hold) rsp.ready <= 0;
    else if (!stall_on) rsp.ready <= 1;
    else rsp.ready <= ($urandom_range(0, 3) != 0);
  end

  // Check outputs.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) board.check_ratio(rsp.factor_ratio, rsp.saturated);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("barrier_factor_ratio_test: done, errors");
      $finish;
    end
  end

  initial begin
    board = new();
    req.valid = 0;
    req.nominal_momentum = '0;
    req.actual_momentum = '0;
    req.angular_order = '0;
    rsp.ready = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: every order at field extremes and equal momenta.
    for (int l = 0; l < 8; l++) begin
      send_item('1, '1, ORD_W'(l));
      send_item('0, '1, ORD_W'(l));
      send_item('1, '0, ORD_W'(l));
    end
    send_item(24'h200000, 24'h200000, 3'd5);
    send_idle(1);

    random_items(120);
    set_radius('1);
    random_items(100);
    set_radius('0);
    send_item('1, '1, 3'd5);
    random_items(30);
    set_radius(16'd8192);

    // Long receiver hold while the sender keeps offering.
    fork
      begin
        long_hold = 1;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      random_items(120);
    join
    stall_on = 0;
    random_items(60);
    stall_on = 1;
    set_radius(16'd1);
    random_items(60);

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d items over five radius settings, all orders, %0d results checked.",
             items_sent, board.checked);
    if (board.mismatches == 0) begin
      $display("barrier_factor_ratio_test: done, clean");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("barrier_factor_ratio_test: done, errors");
    end
    $finish;
  end
endmodule
